// ===== rtl/core/dla_wtg_pkg.sv =====
// ----------------------------------------------------------------------------
// dla_wtg_pkg
// Shared types and codes for the torus-grid aggregation walker.
// ----------------------------------------------------------------------------
package dla_wtg_pkg;

    localparam int CALC_W = 13;

    localparam logic MODE_LAUNCH = 1'b0;
    localparam logic MODE_STEP   = 1'b1;

    typedef enum logic [1:0] {
        DIR_XP = 2'd0,
        DIR_XM = 2'd1,
        DIR_YP = 2'd2,
        DIR_YM = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        NB_E  = 3'd0,
        NB_W  = 3'd1,
        NB_S  = 3'd2,
        NB_N  = 3'd3,
        NB_SE = 3'd4,
        NB_SW = 3'd5,
        NB_NE = 3'd6,
        NB_NW = 3'd7
    } t_nb;

    typedef enum logic [1:0] {
        OP_INC = 2'd0,
        OP_DEC = 2'd1,
        OP_SUB = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CALC_W-1:0] a;
        logic [CALC_W-1:0] lim;
    } t_alu_req;

    typedef struct packed {
        logic [CALC_W-1:0] res;
        logic              ge;
    } t_alu_rsp;

endpackage

// ===== rtl/core/dla_wtg_alu.sv =====
// ----------------------------------------------------------------------------
// dla_wtg_alu
// Shared wrap-around increment, decrement and compare-subtract unit.
// ----------------------------------------------------------------------------
module dla_wtg_alu (
    input  dla_wtg_pkg::t_alu_req i_req,
    output dla_wtg_pkg::t_alu_rsp o_rsp
);
    import dla_wtg_pkg::*;

    logic [CALC_W-1:0] inc;
    logic [CALC_W-1:0] dec;

    assign inc = i_req.a + CALC_W'(1);
    assign dec = i_req.a - CALC_W'(1);

    always_comb begin
        o_rsp = '0;
        case (i_req.op)
            OP_INC: begin
                o_rsp.ge  = (inc >= i_req.lim);
                o_rsp.res = o_rsp.ge ? '0 : inc;
            end
            OP_DEC: begin
                o_rsp.ge  = (i_req.a == '0);
                o_rsp.res = o_rsp.ge ? (i_req.lim - CALC_W'(1)) : dec;
            end
            OP_SUB: begin
                o_rsp.ge  = (i_req.a >= i_req.lim);
                o_rsp.res = o_rsp.ge ? (i_req.a - i_req.lim) : i_req.a;
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/dla_wtg_grid.sv =====
// ----------------------------------------------------------------------------
// dla_wtg_grid
// Single-port occupancy bit memory with registered read data.
// ----------------------------------------------------------------------------
module dla_wtg_grid #(
    parameter int ADDR_W = 20
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_wdata,
    output logic              o_rdata
);
    logic mem [(1 << ADDR_W)];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dla_walker_on_torus_grid_unit.sv =====
// ----------------------------------------------------------------------------
// dla_walker_on_torus_grid_unit
// Diffusion-limited aggregation walker on a wrap-around occupancy grid.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid memory, one cell a cycle, over
// all 2**(clog2(GRID_WIDTH)+clog2(GRID_HEIGHT)) addresses (1048576 at the
// defaults), setting only the centre seed; no item is accepted until the
// sweep ends. Then one item is handled at a time. A step with a walker
// passes through a move state, the wrapped right, left, down and up
// neighbour coordinates in turn on the shared arithmetic unit, eight
// neighbour reads on the single grid port, an evaluation state and, if the
// walker sticks, a write state, then the result load. A launch on the top
// row takes the same path with a launch state in place of the move. A
// launch from the left column adds a row-reduction state that subtracts
// GRID_HEIGHT until the row is below it. A step with no walker goes
// straight to the result load. A finished result waits in the output
// register while the next item is accepted.
// ----------------------------------------------------------------------------
module dla_walker_on_torus_grid_unit #(
    parameter int GRID_WIDTH  = 1024,
    parameter int GRID_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [10:0] i_launch_index,
    input  logic [1:0]  i_direction,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_walker_active,
    output logic        o_stuck,
    output logic [9:0]  o_pos_x,
    output logic [9:0]  o_pos_y,
    output logic [3:0]  o_neighbour_count
);
    import dla_wtg_pkg::*;

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int AW = XW + YW;
    localparam logic [AW-1:0] SEED_ADDR = {YW'(GRID_HEIGHT / 2), XW'(GRID_WIDTH / 2)};
    localparam logic [CALC_W-1:0] LIM_X = CALC_W'(GRID_WIDTH);
    localparam logic [CALC_W-1:0] LIM_Y = CALC_W'(GRID_HEIGHT);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_LAUNCH = 13'b0000000000100,
        S_MOD    = 13'b0000000001000,
        S_MOVE   = 13'b0000000010000,
        S_XR     = 13'b0000000100000,
        S_XL     = 13'b0000001000000,
        S_YD     = 13'b0000010000000,
        S_YU     = 13'b0000100000000,
        S_READ   = 13'b0001000000000,
        S_LAST   = 13'b0010000000000,
        S_WRITE  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_busy, n_busy;
    logic [XW-1:0]     r_wx, n_wx;
    logic [YW-1:0]     r_wy, n_wy;
    logic [XW-1:0]     r_xr, n_xr;
    logic [XW-1:0]     r_xl, n_xl;
    logic [YW-1:0]     r_yd, n_yd;
    logic [YW-1:0]     r_yu, n_yu;
    logic [10:0]       r_s, n_s;
    t_dir              r_dir, n_dir;
    logic [CALC_W-1:0] r_t, n_t;
    t_nb               r_nb, n_nb;
    logic              r_pend, n_pend;
    logic [3:0]        r_count, n_count;
    logic              r_active, n_active;
    logic              r_stuck, n_stuck;
    logic              r_ovalid, n_ovalid;
    logic              r_o_active, n_o_active;
    logic              r_o_stuck, n_o_stuck;
    logic [9:0]        r_o_x, n_o_x;
    logic [9:0]        r_o_y, n_o_y;
    logic [3:0]        r_o_count, n_o_count;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic              mem_wdata;
    logic              mem_rdata;
    logic [3:0]        last_count;

    dla_wtg_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    dla_wtg_grid #(
        .ADDR_W (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign last_count = r_count + 4'(mem_rdata);

    always_comb begin
        alu_req = '{op: OP_SUB, a: '0, lim: '0};
        case (r_state)
            S_LAUNCH: alu_req = '{op: OP_SUB, a: CALC_W'(r_s), lim: LIM_X};
            S_MOD:    alu_req = '{op: OP_SUB, a: r_t, lim: LIM_Y};
            S_MOVE: begin
                case (r_dir)
                    DIR_XP:  alu_req = '{op: OP_INC, a: CALC_W'(r_wx), lim: LIM_X};
                    DIR_XM:  alu_req = '{op: OP_DEC, a: CALC_W'(r_wx), lim: LIM_X};
                    DIR_YP:  alu_req = '{op: OP_INC, a: CALC_W'(r_wy), lim: LIM_Y};
                    default: alu_req = '{op: OP_DEC, a: CALC_W'(r_wy), lim: LIM_Y};
                endcase
            end
            S_XR:    alu_req = '{op: OP_INC, a: CALC_W'(r_wx), lim: LIM_X};
            S_XL:    alu_req = '{op: OP_DEC, a: CALC_W'(r_wx), lim: LIM_X};
            S_YD:    alu_req = '{op: OP_INC, a: CALC_W'(r_wy), lim: LIM_Y};
            S_YU:    alu_req = '{op: OP_DEC, a: CALC_W'(r_wy), lim: LIM_Y};
            default: alu_req = '{op: OP_SUB, a: '0, lim: '0};
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = {r_wy, r_wx};
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = (r_clr == SEED_ADDR);
            end
            S_READ: begin
                mem_re = 1'b1;
                case (r_nb)
                    NB_E:    mem_addr = {r_wy, r_xr};
                    NB_W:    mem_addr = {r_wy, r_xl};
                    NB_S:    mem_addr = {r_yd, r_wx};
                    NB_N:    mem_addr = {r_yu, r_wx};
                    NB_SE:   mem_addr = {r_yd, r_xr};
                    NB_SW:   mem_addr = {r_yd, r_xl};
                    NB_NE:   mem_addr = {r_yu, r_xr};
                    default: mem_addr = {r_yu, r_xl};
                endcase
            end
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_busy     = r_busy;
        n_wx       = r_wx;
        n_wy       = r_wy;
        n_xr       = r_xr;
        n_xl       = r_xl;
        n_yd       = r_yd;
        n_yu       = r_yu;
        n_s        = r_s;
        n_dir      = r_dir;
        n_t        = r_t;
        n_nb       = r_nb;
        n_pend     = (r_state == S_READ);
        n_count    = r_count;
        n_active   = r_active;
        n_stuck    = r_stuck;
        n_ovalid   = r_ovalid && !i_ready;
        n_o_active = r_o_active;
        n_o_stuck  = r_o_stuck;
        n_o_x      = r_o_x;
        n_o_y      = r_o_y;
        n_o_count  = r_o_count;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_s      = i_launch_index;
                    n_dir    = t_dir'(i_direction);
                    n_active = 1'b0;
                    n_stuck  = 1'b0;
                    n_count  = '0;
                    if (i_mode == MODE_LAUNCH) begin
                        n_state = S_LAUNCH;
                    end else if (r_busy) begin
                        n_state = S_MOVE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LAUNCH: begin
                n_busy   = 1'b1;
                n_active = 1'b1;
                if (alu_rsp.ge) begin
                    n_t     = alu_rsp.res;
                    n_state = S_MOD;
                end else begin
                    n_wx    = XW'(alu_rsp.res);
                    n_wy    = '0;
                    n_state = S_XR;
                end
            end
            S_MOD: begin
                if (alu_rsp.ge) begin
                    n_t = alu_rsp.res;
                end else begin
                    n_wx    = '0;
                    n_wy    = YW'(alu_rsp.res);
                    n_state = S_XR;
                end
            end
            S_MOVE: begin
                n_active = 1'b1;
                if (r_dir == DIR_XP || r_dir == DIR_XM) begin
                    n_wx = XW'(alu_rsp.res);
                end else begin
                    n_wy = YW'(alu_rsp.res);
                end
                n_state = S_XR;
            end
            S_XR: begin
                n_xr    = XW'(alu_rsp.res);
                n_state = S_XL;
            end
            S_XL: begin
                n_xl    = XW'(alu_rsp.res);
                n_state = S_YD;
            end
            S_YD: begin
                n_yd    = YW'(alu_rsp.res);
                n_state = S_YU;
            end
            S_YU: begin
                n_yu    = YW'(alu_rsp.res);
                n_count = '0;
                n_nb    = NB_E;
                n_state = S_READ;
            end
            S_READ: begin
                if (r_pend) begin
                    n_count = last_count;
                end
                if (r_nb == NB_NW) begin
                    n_state = S_LAST;
                end else begin
                    n_nb = t_nb'(r_nb + 3'd1);
                end
            end
            S_LAST: begin
                n_count = last_count;
                n_state = (last_count != '0) ? S_WRITE : S_DONE;
            end
            S_WRITE: begin
                n_busy  = 1'b0;
                n_stuck = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid   = 1'b1;
                    n_o_active = r_active;
                    n_o_stuck  = r_stuck;
                    n_o_x      = 10'(r_wx);
                    n_o_y      = 10'(r_wy);
                    n_o_count  = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_busy   <= 1'b0;
            r_wx     <= '0;
            r_wy     <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_busy   <= n_busy;
            r_wx     <= n_wx;
            r_wy     <= n_wy;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xr       <= n_xr;
        r_xl       <= n_xl;
        r_yd       <= n_yd;
        r_yu       <= n_yu;
        r_s        <= n_s;
        r_dir      <= n_dir;
        r_t        <= n_t;
        r_nb       <= n_nb;
        r_count    <= n_count;
        r_active   <= n_active;
        r_stuck    <= n_stuck;
        r_o_active <= n_o_active;
        r_o_stuck  <= n_o_stuck;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_count  <= n_o_count;
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_ovalid;
    assign o_walker_active   = r_o_active;
    assign o_stuck           = r_o_stuck;
    assign o_pos_x           = r_o_x;
    assign o_pos_y           = r_o_y;
    assign o_neighbour_count = r_o_count;

`ifndef SYNTHESIS
    a_stuck_needs_walker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stuck |-> o_walker_active && (o_neighbour_count != 4'd0))
        else $error("stuck result without walker or neighbours");

    a_idle_step_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_walker_active |-> !o_stuck && (o_neighbour_count == 4'd0))
        else $error("idle step reported activity");

    a_write_retires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> !r_busy && r_stuck)
        else $error("walker not retired after grid write");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready && !mem_re)
        else $error("grid accessed for an item during clearing sweep");
`endif

endmodule
